// ===== sv/m4i_pkg.sv =====
`default_nettype none

package m4i_pkg;

  localparam int ELEM_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int WIDE_W     = 64;
  localparam int EPS_W      = 31;
  localparam int K_W        = 4;

  localparam logic signed [WIDE_W-1:0] WIDE_MAX = {1'b0, {(WIDE_W-1){1'b1}}};

  // micro step numbers of one cofactor (plus the determinant product)
  localparam logic [K_W-1:0] K_COF_LAST = 4'd8;
  localparam logic [K_W-1:0] K_DET_MUL  = 4'd9;

  // second multiplier operand source
  localparam logic [2:0] BSRC_ELEM = 3'd0;
  localparam logic [2:0] BSRC_T0   = 3'd1;
  localparam logic [2:0] BSRC_T1   = 3'd2;
  localparam logic [2:0] BSRC_T2   = 3'd3;
  localparam logic [2:0] BSRC_COF  = 3'd4;

  // accumulate destination
  localparam logic [2:0] DST_T  = 3'd0;
  localparam logic [2:0] DST_T0 = 3'd1;
  localparam logic [2:0] DST_T1 = 3'd2;
  localparam logic [2:0] DST_T2 = 3'd3;
  localparam logic [2:0] DST_S  = 3'd4;
  localparam logic [2:0] DST_D  = 3'd5;

  localparam logic [1:0] ACC_SET = 2'd0;
  localparam logic [1:0] ACC_ADD = 2'd1;
  localparam logic [1:0] ACC_SUB = 2'd2;

  typedef struct packed {
    logic [1:0]                   column_index;
    logic signed [ELEM_WIDTH-1:0] elem_x;
    logic signed [ELEM_WIDTH-1:0] elem_y;
    logic signed [ELEM_WIDTH-1:0] elem_z;
    logic signed [ELEM_WIDTH-1:0] elem_w;
    logic                         load_last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                   out_column;
    logic signed [ELEM_WIDTH-1:0] res_x;
    logic signed [ELEM_WIDTH-1:0] res_y;
    logic signed [ELEM_WIDTH-1:0] res_z;
    logic signed [ELEM_WIDTH-1:0] res_w;
    logic                         singular;
    logic                         overflowed;
    logic                         out_last;
  } out_item_t;

  typedef struct packed {
    logic [1:0] ai;
    logic [1:0] aj;
    logic [1:0] bi;
    logic [1:0] bj;
    logic [2:0] bsrc;
    logic [2:0] dst;
    logic [1:0] mode;
  } uop_t;

  typedef struct packed {
    logic           load;
    logic           rd;
    logic           mul_start;
    logic           acc;
    logic           chk;
    logic           div_start;
    logic           res_wr;
    logic           copy_rd;
    logic           copy_wr;
    logic           out_load;
    logic [K_W-1:0] k;
    logic [1:0]     cc;
    logic [1:0]     rr;
    logic [1:0]     col;
    logic [1:0]     row;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic singular;
    logic out_free;
  } sts_t;

  // 3x3 minor expanded along its first column, a[col][row]
  function automatic uop_t uop_of(input logic [K_W-1:0] k);
    uop_t u;
    u = '0;
    case (k)
      4'd0: begin
        u.ai = 2'd1; u.aj = 2'd1; u.bi = 2'd2; u.bj = 2'd2;
        u.bsrc = BSRC_ELEM; u.dst = DST_T; u.mode = ACC_SET;
      end
      4'd1: begin
        u.ai = 2'd2; u.aj = 2'd1; u.bi = 2'd1; u.bj = 2'd2;
        u.bsrc = BSRC_ELEM; u.dst = DST_T0; u.mode = ACC_SUB;
      end
      4'd2: begin
        u.ai = 2'd1; u.aj = 2'd0; u.bi = 2'd2; u.bj = 2'd2;
        u.bsrc = BSRC_ELEM; u.dst = DST_T; u.mode = ACC_SET;
      end
      4'd3: begin
        u.ai = 2'd2; u.aj = 2'd0; u.bi = 2'd1; u.bj = 2'd2;
        u.bsrc = BSRC_ELEM; u.dst = DST_T1; u.mode = ACC_SUB;
      end
      4'd4: begin
        u.ai = 2'd1; u.aj = 2'd0; u.bi = 2'd2; u.bj = 2'd1;
        u.bsrc = BSRC_ELEM; u.dst = DST_T; u.mode = ACC_SET;
      end
      4'd5: begin
        u.ai = 2'd2; u.aj = 2'd0; u.bi = 2'd1; u.bj = 2'd1;
        u.bsrc = BSRC_ELEM; u.dst = DST_T2; u.mode = ACC_SUB;
      end
      4'd6: begin
        u.ai = 2'd0; u.aj = 2'd0;
        u.bsrc = BSRC_T0; u.dst = DST_S; u.mode = ACC_SET;
      end
      4'd7: begin
        u.ai = 2'd0; u.aj = 2'd1;
        u.bsrc = BSRC_T1; u.dst = DST_S; u.mode = ACC_SUB;
      end
      4'd8: begin
        u.ai = 2'd0; u.aj = 2'd2;
        u.bsrc = BSRC_T2; u.dst = DST_S; u.mode = ACC_ADD;
      end
      4'd9: begin
        u.bsrc = BSRC_COF; u.dst = DST_D; u.mode = ACC_ADD;
      end
      default: begin
        u = '0;
      end
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

// ===== sv/m4i_mul.sv =====
`default_nettype none

module m4i_mul
  import m4i_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic signed [ELEM_WIDTH-1:0] a,
  input  wire logic signed [WIDE_W-1:0]     b,
  output logic                              done,
  output logic signed [WIDE_W-1:0]          prod,
  output logic                              sat
);

  localparam int CHUNK  = 16;
  localparam int NCHUNK = WIDE_W / CHUNK;
  localparam int PW     = ELEM_WIDTH + WIDE_W;
  localparam int CNT_W  = $clog2(NCHUNK);

  localparam logic [1:0] MS_IDLE = 2'd0;
  localparam logic [1:0] MS_RUN  = 2'd1;
  localparam logic [1:0] MS_RND  = 2'd2;
  localparam logic [1:0] MS_SGN  = 2'd3;

  logic [1:0]              state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    done_r;
  logic [ELEM_WIDTH-1:0]   a_mag_r;
  logic [WIDE_W-1:0]       b_r;
  logic                    neg_r;
  logic [PW-1:0]           acc_r;
  logic [WIDE_W-1:0]       q_r;
  logic                    sat_r;
  logic signed [WIDE_W-1:0] prod_r;

  logic [ELEM_WIDTH:0]        a_ext, a_neg;
  logic [WIDE_W-1:0]          b_neg;
  logic [ELEM_WIDTH+CHUNK-1:0] part;
  logic [PW:0]                rnd, shifted;
  logic                       rnd_sat;

  assign a_ext   = {a[ELEM_WIDTH-1], a};
  assign a_neg   = -a_ext;
  assign b_neg   = -b;
  assign part    = a_mag_r * b_r[WIDE_W-1 -: CHUNK];
  assign rnd     = {1'b0, acc_r} + ((PW+1)'(1) << (FRAC_BITS - 1));
  assign shifted = rnd >> FRAC_BITS;
  assign rnd_sat = |shifted[PW:WIDE_W-1];

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      MS_IDLE: begin
        if (start) begin
          state_nxt = MS_RUN;
          cnt_nxt   = '0;
        end
      end
      MS_RUN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NCHUNK - 1)) begin
          state_nxt = MS_RND;
        end
      end
      MS_RND:  state_nxt = MS_SGN;
      MS_SGN:  state_nxt = MS_IDLE;
      default: state_nxt = MS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MS_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= (state_r == MS_SGN);
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      MS_IDLE: begin
        if (start) begin
          a_mag_r <= a[ELEM_WIDTH-1] ? a_neg[ELEM_WIDTH-1:0] : a_ext[ELEM_WIDTH-1:0];
          b_r     <= b[WIDE_W-1] ? b_neg : b;
          neg_r   <= a[ELEM_WIDTH-1] ^ b[WIDE_W-1];
          acc_r   <= '0;
        end
      end
      MS_RUN: begin
        acc_r <= (acc_r << CHUNK) + {{(PW-ELEM_WIDTH-CHUNK){1'b0}}, part};
        b_r   <= b_r << CHUNK;
      end
      MS_RND: begin
        sat_r <= rnd_sat;
        q_r   <= rnd_sat ? WIDE_MAX : shifted[WIDE_W-1:0];
      end
      MS_SGN: begin
        prod_r <= neg_r ? -q_r : q_r;
      end
      default: begin
      end
    endcase
  end

  assign done = done_r;
  assign prod = prod_r;
  assign sat  = sat_r;

endmodule

`default_nettype wire

// ===== sv/m4i_div.sv =====
`default_nettype none

module m4i_div
  import m4i_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic signed [WIDE_W-1:0] num,
  input  wire logic signed [WIDE_W-1:0] den,
  output logic                          done,
  output logic signed [ELEM_WIDTH-1:0]  quo,
  output logic                          sat
);

  localparam int DVW   = WIDE_W + FRAC_BITS;
  localparam int CNT_W = $clog2(DVW);

  localparam logic [1:0] DS_IDLE = 2'd0;
  localparam logic [1:0] DS_RUN  = 2'd1;
  localparam logic [1:0] DS_FIN  = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  done_r;
  logic [DVW-1:0]        dvd_r;
  logic [DVW-1:0]        q_r;
  logic [WIDE_W:0]       rem_r;
  logic [WIDE_W-1:0]     den_r;
  logic                  neg_r;
  logic signed [ELEM_WIDTH-1:0] quo_r;
  logic                  sat_r;

  logic [WIDE_W-1:0]     num_mag, den_mag;
  logic [WIDE_W:0]       rem_sh;
  logic                  qb;
  logic [DVW-1:0]        lim, qv;
  logic                  fin_sat;
  logic [ELEM_WIDTH:0]   qn;

  assign num_mag = num[WIDE_W-1] ? -num : num;
  assign den_mag = den[WIDE_W-1] ? -den : den;
  assign rem_sh  = {rem_r[WIDE_W-1:0], dvd_r[DVW-1]};
  assign qb      = rem_sh >= {1'b0, den_r};
  assign lim     = (DVW'(1) << (ELEM_WIDTH - 1)) - (neg_r ? DVW'(0) : DVW'(1));
  assign fin_sat = q_r > lim;
  assign qv      = fin_sat ? lim : q_r;
  assign qn      = qv[ELEM_WIDTH:0];

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      DS_IDLE: begin
        if (start) begin
          state_nxt = DS_RUN;
          cnt_nxt   = '0;
        end
      end
      DS_RUN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DVW - 1)) begin
          state_nxt = DS_FIN;
        end
      end
      DS_FIN:  state_nxt = DS_IDLE;
      default: state_nxt = DS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DS_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= (state_r == DS_FIN);
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      DS_IDLE: begin
        if (start) begin
          dvd_r <= {num_mag, {FRAC_BITS{1'b0}}};
          den_r <= den_mag;
          neg_r <= num[WIDE_W-1] ^ den[WIDE_W-1];
          rem_r <= '0;
          q_r   <= '0;
        end
      end
      DS_RUN: begin
        // one quotient bit per cycle, restoring
        rem_r <= qb ? rem_sh - {1'b0, den_r} : rem_sh;
        q_r   <= {q_r[DVW-2:0], qb};
        dvd_r <= dvd_r << 1;
      end
      DS_FIN: begin
        sat_r <= fin_sat;
        quo_r <= neg_r ? ELEM_WIDTH'(-qn) : qn[ELEM_WIDTH-1:0];
      end
      default: begin
      end
    endcase
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign sat  = sat_r;

endmodule

`default_nettype wire

// ===== sv/m4i_dp.sv =====
`default_nettype none

module m4i_dp
  import m4i_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire in_item_t        in_data,
  input  wire logic            cfg_we,
  input  wire logic [EPS_W-1:0] cfg_data,
  input  wire cmd_t            cmd,
  output sts_t                 sts,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output out_item_t            out_data
);

  localparam int ROW_W = 4 * ELEM_WIDTH;

  logic [ROW_W-1:0]  mem [0:3];
  logic [ROW_W-1:0]  rda_q, rdb_q;
  logic [3:0]        loaded_r;
  logic [3:0]        mask_r;
  logic [EPS_W-1:0]  eps_r;

  logic signed [WIDE_W-1:0] t_r, t0_r, t1_r, t2_r, s_r, d_r;
  logic              wide_r;
  logic [3:0]        colsat_r;
  logic              singular_r;
  logic [ROW_W-1:0]  res_r [0:3];
  logic              out_valid_r;
  out_item_t         out_data_r;

  uop_t              u;
  logic              is_det_mul;
  logic [1:0]        col_a, row_a, col_b, row_b, addr_a;
  logic signed [ELEM_WIDTH-1:0] elem_a, elem_b;
  logic signed [WIDE_W-1:0] cof, b_val, base, addend, acc_val;
  logic [WIDE_W:0]   add_res;
  logic              sat_any;
  logic [WIDE_W-1:0] det_mag;
  logic              singular_cmb;
  logic              out_free;

  logic                     mul_done, mul_sat;
  logic signed [WIDE_W-1:0] mul_prod;
  logic                     div_done, div_sat;
  logic signed [ELEM_WIDTH-1:0] div_quo;

  function automatic logic [1:0] map_idx(input logic [1:0] i, input logic [1:0] skip);
    return (i < skip) ? i : i + 2'd1;
  endfunction

  // saturating add in the symmetric wide range, msb is the saturation flag
  function automatic logic [WIDE_W:0] qadd(input logic signed [WIDE_W-1:0] a,
                                           input logic signed [WIDE_W-1:0] b);
    logic signed [WIDE_W:0] s;
    logic signed [WIDE_W:0] hi;
    s  = {a[WIDE_W-1], a} + {b[WIDE_W-1], b};
    hi = {1'b0, WIDE_MAX};
    if (s > hi) begin
      return {1'b1, WIDE_MAX};
    end else if (s < -hi) begin
      return {1'b1, -WIDE_MAX};
    end
    return {1'b0, s[WIDE_W-1:0]};
  endfunction

  assign u          = uop_of(cmd.k);
  assign is_det_mul = (cmd.k == K_DET_MUL);
  assign col_a      = is_det_mul ? 2'd0 : map_idx(u.ai, cmd.cc);
  assign row_a      = is_det_mul ? cmd.rr : map_idx(u.aj, cmd.rr);
  assign col_b      = map_idx(u.bi, cmd.cc);
  assign row_b      = map_idx(u.bj, cmd.rr);
  assign addr_a     = cmd.copy_rd ? cmd.col : col_a;

  assign elem_a = mask_r[col_a] ? rda_q[row_a*ELEM_WIDTH +: ELEM_WIDTH] : '0;
  assign elem_b = mask_r[col_b] ? rdb_q[row_b*ELEM_WIDTH +: ELEM_WIDTH] : '0;
  assign cof    = (cmd.cc[0] ^ cmd.rr[0]) ? -s_r : s_r;

  always_comb begin
    case (u.bsrc)
      BSRC_ELEM: b_val = {{(WIDE_W-ELEM_WIDTH){elem_b[ELEM_WIDTH-1]}}, elem_b};
      BSRC_T0:   b_val = t0_r;
      BSRC_T1:   b_val = t1_r;
      BSRC_T2:   b_val = t2_r;
      BSRC_COF:  b_val = cof;
      default:   b_val = '0;
    endcase
  end

  always_comb begin
    case (u.dst)
      DST_T0, DST_T1, DST_T2: base = t_r;
      DST_S:                  base = s_r;
      DST_D:                  base = d_r;
      default:                base = t_r;
    endcase
  end

  assign addend  = (u.mode == ACC_SUB) ? -mul_prod : mul_prod;
  assign add_res = qadd(base, addend);
  assign acc_val = (u.mode == ACC_SET) ? mul_prod : add_res[WIDE_W-1:0];
  assign sat_any = mul_sat | ((u.mode != ACC_SET) & add_res[WIDE_W]);

  assign det_mag      = d_r[WIDE_W-1] ? -d_r : d_r;
  assign singular_cmb = det_mag <= {{(WIDE_W-EPS_W){1'b0}}, eps_r};
  assign out_free     = !out_valid_r || !out_stall;

  m4i_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (elem_a),
    .b     (b_val),
    .done  (mul_done),
    .prod  (mul_prod),
    .sat   (mul_sat)
  );

  m4i_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (cof),
    .den   (d_r),
    .done  (div_done),
    .quo   (div_quo),
    .sat   (div_sat)
  );

  // column store, one row per column
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[in_data.column_index] <= {in_data.elem_w, in_data.elem_z,
                                    in_data.elem_y, in_data.elem_x};
    end
    if (cmd.rd || cmd.copy_rd) begin
      rda_q <= mem[addr_a];
      rdb_q <= mem[col_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r    <= '0;
      eps_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        eps_r <= cfg_data;
      end
      if (cmd.load) begin
        loaded_r <= in_data.load_last ? 4'b0000
                    : (loaded_r | (4'b0001 << in_data.column_index));
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && in_data.load_last) begin
      mask_r   <= loaded_r | (4'b0001 << in_data.column_index);
      d_r      <= '0;
      wide_r   <= 1'b0;
      colsat_r <= '0;
    end
    if (cmd.acc) begin
      wide_r <= wide_r | sat_any;
      case (u.dst)
        DST_T:   t_r  <= acc_val;
        DST_T0:  t0_r <= acc_val;
        DST_T1:  t1_r <= acc_val;
        DST_T2:  t2_r <= acc_val;
        DST_S:   s_r  <= acc_val;
        DST_D:   d_r  <= acc_val;
        default: t_r  <= acc_val;
      endcase
    end
    if (cmd.chk) begin
      singular_r <= singular_cmb;
    end
    if (cmd.res_wr) begin
      res_r[cmd.col][cmd.row*ELEM_WIDTH +: ELEM_WIDTH] <= div_quo;
      colsat_r[cmd.col] <= colsat_r[cmd.col] | div_sat;
    end
    if (cmd.copy_wr) begin
      res_r[cmd.col] <= mask_r[cmd.col] ? rda_q : '0;
    end
    if (cmd.out_load) begin
      out_data_r.out_column <= cmd.col;
      out_data_r.res_x      <= res_r[cmd.col][0*ELEM_WIDTH +: ELEM_WIDTH];
      out_data_r.res_y      <= res_r[cmd.col][1*ELEM_WIDTH +: ELEM_WIDTH];
      out_data_r.res_z      <= res_r[cmd.col][2*ELEM_WIDTH +: ELEM_WIDTH];
      out_data_r.res_w      <= res_r[cmd.col][3*ELEM_WIDTH +: ELEM_WIDTH];
      out_data_r.singular   <= singular_r;
      out_data_r.overflowed <= !singular_r && (colsat_r[cmd.col] || wide_r);
      out_data_r.out_last   <= (cmd.col == 2'd3);
    end
  end

  assign sts.mul_done = mul_done;
  assign sts.div_done = div_done;
  assign sts.singular = singular_cmb;
  assign sts.out_free = out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assert property (@(posedge clk) disable iff (!rst_n) cmd.acc |-> mul_done)
    else $error("accumulate without a finished product");
  assert property (@(posedge clk) disable iff (!rst_n) cmd.div_start |-> d_r != '0)
    else $error("division started with zero determinant");
  assert property (@(posedge clk) disable iff (!rst_n) !(mul_done && div_done))
    else $error("multiplier and divider finished together");
  assert property (@(posedge clk) disable iff (!rst_n) cmd.res_wr |-> !singular_r)
    else $error("quotient written for a singular matrix");

endmodule

`default_nettype wire

// ===== sv/m4i_ctrl.sv =====
`default_nettype none

module m4i_ctrl
  import m4i_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire logic in_last,
  output logic      in_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_RD    = 4'd1;
  localparam logic [3:0] ST_MUL   = 4'd2;
  localparam logic [3:0] ST_WAIT  = 4'd3;
  localparam logic [3:0] ST_CHK   = 4'd4;
  localparam logic [3:0] ST_DIV   = 4'd5;
  localparam logic [3:0] ST_DWAIT = 4'd6;
  localparam logic [3:0] ST_CPRD  = 4'd7;
  localparam logic [3:0] ST_CPWR  = 4'd8;
  localparam logic [3:0] ST_OUT   = 4'd9;

  logic [3:0]     state_r, state_nxt;
  logic [K_W-1:0] k_r, k_nxt;
  logic [1:0]     col_r, col_nxt;
  logic [1:0]     row_r, row_nxt;
  logic           inv_r, inv_nxt;

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    inv_nxt   = inv_r;
    cmd       = '0;
    cmd.k     = k_r;
    // determinant pass: cofactor of column 0, row r; inverse pass: remove column r, row c
    cmd.cc    = inv_r ? row_r : 2'd0;
    cmd.rr    = inv_r ? col_r : row_r;
    cmd.col   = col_r;
    cmd.row   = row_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) begin
            state_nxt = ST_RD;
            k_nxt     = '0;
            col_nxt   = 2'd0;
            row_nxt   = 2'd0;
            inv_nxt   = 1'b0;
          end
        end
      end
      ST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_start = 1'b1;
        state_nxt     = ST_WAIT;
      end
      ST_WAIT: begin
        if (sts.mul_done) begin
          cmd.acc = 1'b1;
          if (inv_r && k_r == K_COF_LAST) begin
            state_nxt = ST_DIV;
          end else if (!inv_r && k_r == K_DET_MUL) begin
            k_nxt = '0;
            if (row_r == 2'd3) begin
              state_nxt = ST_CHK;
            end else begin
              row_nxt   = row_r + 2'd1;
              state_nxt = ST_RD;
            end
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = ST_RD;
          end
        end
      end
      ST_CHK: begin
        cmd.chk = 1'b1;
        row_nxt = 2'd0;
        col_nxt = 2'd0;
        k_nxt   = '0;
        if (sts.singular) begin
          state_nxt = ST_CPRD;
        end else begin
          inv_nxt   = 1'b1;
          state_nxt = ST_RD;
        end
      end
      ST_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (sts.div_done) begin
          cmd.res_wr = 1'b1;
          k_nxt      = '0;
          if (row_r == 2'd3) begin
            row_nxt = 2'd0;
            if (col_r == 2'd3) begin
              col_nxt   = 2'd0;
              state_nxt = ST_OUT;
            end else begin
              col_nxt   = col_r + 2'd1;
              state_nxt = ST_RD;
            end
          end else begin
            row_nxt   = row_r + 2'd1;
            state_nxt = ST_RD;
          end
        end
      end
      ST_CPRD: begin
        cmd.copy_rd = 1'b1;
        state_nxt   = ST_CPWR;
      end
      ST_CPWR: begin
        cmd.copy_wr = 1'b1;
        if (col_r == 2'd3) begin
          col_nxt   = 2'd0;
          state_nxt = ST_OUT;
        end else begin
          col_nxt   = col_r + 2'd1;
          state_nxt = ST_CPRD;
        end
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (col_r == 2'd3) begin
            col_nxt   = 2'd0;
            state_nxt = ST_IDLE;
          end else begin
            col_nxt = col_r + 2'd1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= '0;
      col_r   <= 2'd0;
      row_r   <= 2'd0;
      inv_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      inv_r   <= inv_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

`default_nettype wire

// ===== sv/matrix4_inverse_core.sv =====
// channel  | direction | handshake         | payload
// ---------+-----------+-------------------+------------------------------
// in_      | in        | in_valid/in_stall | in_item_t, one matrix column
// out_     | out       | out_valid/out_stall | out_item_t, one result column
// cfg_     | in        | cfg_valid/cfg_ready | singular epsilon, 31 bits
//
// a column item that is not last is taken while the block is idle, without a stall
// the last column starts an inversion, whose run time is set by
// the one shared multiplier (four partial products from 16-bit chunks per multiply step,
// 184 steps when not singular) and the one-bit-per-cycle divider (one run for each of the 16 quotients)
// reset (rst_n, synchronous) clears the loaded-column bits, epsilon and the output valid flag
// out_stall holds the output register; the next column item waits until all four
// results have been loaded into the output register
`default_nettype none

module matrix4_inverse_core
  import m4i_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_item_t             out_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [EPS_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  m4i_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.load_last),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  m4i_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
